/* rtl/vtpd_pkg.sv */
// ----------------------------------------------------------------------------
// vtpd_pkg
// Shared types and constants for the vertex transform and perspective divide.
// ----------------------------------------------------------------------------
package vtpd_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DW        = 32;
    localparam int ACC_W     = 2 * DW + 2;
    localparam int DVD_W     = DW + FRAC_BITS;
    localparam int CNT_W     = $clog2(DVD_W + 1);

    localparam logic signed [DW-1:0]    ONE_Q  = DW'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [ACC_W-1:0] HALF_Q = ACC_W'(64'sd1 <<< (FRAC_BITS - 1));
    localparam logic signed [DW-1:0]    MAX_Q  = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0]    MIN_Q  = {1'b1, {(DW-1){1'b0}}};

    localparam logic [2:0] ADDR_TOL = 3'd0;

    typedef enum logic [1:0] {
        CMD_SET   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_POINT = 2'd2,
        CMD_DIR   = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t                  cmd;
        logic [3:0]            idx;
        logic signed [DW-1:0]  val;
        logic signed [DW-1:0]  x;
        logic signed [DW-1:0]  y;
        logic signed [DW-1:0]  z;
    } item_t;

    typedef struct packed {
        logic                  valid;
        item_t                 item;
    } qslot_t;

endpackage

/* rtl/vtpd_front.sv */
// ----------------------------------------------------------------------------
// vtpd_front
// Input stage: registers and decodes one transaction, hands it to the queue.
// ----------------------------------------------------------------------------
module vtpd_front
    import vtpd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,
    input  logic [1:0]   s_tuser,
    output qslot_t       push,
    input  logic         full
);

    logic  fv_reg;
    item_t item_reg;
    logic  go;

    assign go       = fv_reg && !full;
    assign s_tready = !fv_reg || !full;
    assign push     = '{valid: go, item: item_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            fv_reg <= 1'b1;
        end else if (go) begin
            fv_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.cmd <= cmd_t'(s_tuser);
            item_reg.idx <= s_tdata[3:0];
            item_reg.val <= s_tdata[35:4];
            item_reg.x   <= s_tdata[67:36];
            item_reg.y   <= s_tdata[99:68];
            item_reg.z   <= s_tdata[131:100];
        end
    end

endmodule

/* rtl/vtpd_queue.sv */
// ----------------------------------------------------------------------------
// vtpd_queue
// Two-entry queue between the input stage and the compute engine.
// ----------------------------------------------------------------------------
module vtpd_queue
    import vtpd_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  qslot_t push,
    output logic   full,
    output logic   empty,
    input  logic   pop,
    output item_t  head
);

    item_t      q_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign head  = q_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push.valid) wp_reg <= ~wp_reg;
            if (pop)        rp_reg <= ~rp_reg;
            if (push.valid && !pop)      cnt_reg <= cnt_reg + 2'd1;
            else if (!push.valid && pop) cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.valid) q_reg[wp_reg] <= push.item;
    end

endmodule

/* rtl/vtpd_back.sv */
// ----------------------------------------------------------------------------
// vtpd_back
// Compute engine: matrix store, shared multiply-accumulate, serial divider.
// ----------------------------------------------------------------------------
module vtpd_back
    import vtpd_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          empty,
    output logic          pop,
    input  item_t         head,
    input  logic [15:0]   tol,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [127:0]  m_tdata,
    output logic [1:0]    m_tuser
);

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_MUL, S_ACC, S_ROW, S_CHK, S_DSTART, S_DIV, S_DEND, S_FIN
    } state_t;

    state_t                  st_reg;
    item_t                   it_reg;
    logic [1:0]              r_reg, k_reg, ch_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [2*DW-1:0]  prod_reg;
    logic signed [DW-1:0]    sum_reg [4];
    logic signed [DW-1:0]    rv_reg;
    logic                    sat_reg, div_reg;
    logic [DW:0]             rem_reg;
    logic [DW-1:0]           dvs_reg;
    logic [DVD_W-1:0]        dvd_reg, quo_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    ov_reg;
    logic [127:0]            od_reg;
    logic [1:0]              ou_reg;

    logic signed [DW-1:0]    mem [16];
    logic [15:0]             mv_reg;
    logic signed [DW-1:0]    mq_reg;
    logic                    mqv_reg, mqi_reg;
    logic [3:0]              maddr;
    logic signed [DW-1:0]    rdata;
    logic                    mwe;

    logic signed [DW-1:0]    vec;
    logic signed [ACC_W-1:0] rs, sh;
    logic                    ovf;
    logic signed [DW-1:0]    rowv;
    logic signed [DW:0]      wd, wad;
    logic signed [DW-1:0]    w, num;
    logic [DW:0]             rsh;
    logic                    neg;
    logic                    pt;

    assign pop      = (st_reg == S_IDLE) && !empty;
    assign mwe      = pop && (head.cmd == CMD_SET);
    assign maddr    = (it_reg.cmd == CMD_READ) ? it_reg.idx : {k_reg, r_reg};
    assign rdata    = mqv_reg ? mq_reg : (mqi_reg ? ONE_Q : '0);
    assign pt       = (it_reg.cmd == CMD_POINT);
    assign w        = sum_reg[3];
    assign num      = sum_reg[ch_reg];
    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;
    assign m_tuser  = ou_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) mv_reg <= '0;
        else if (mwe) mv_reg[head.idx] <= 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (mwe) mem[head.idx] <= head.val;
        mq_reg  <= mem[maddr];
        mqv_reg <= mv_reg[maddr];
        mqi_reg <= (maddr[1:0] == maddr[3:2]);
    end

    always_comb begin
        case (k_reg)
            2'd0:    vec = it_reg.x;
            2'd1:    vec = it_reg.y;
            2'd2:    vec = it_reg.z;
            default: vec = pt ? ONE_Q : '0;
        endcase
        rs   = acc_reg + HALF_Q;
        sh   = rs >>> FRAC_BITS;
        ovf  = !((&sh[ACC_W-1:DW-1]) || !(|sh[ACC_W-1:DW-1]));
        rowv = ovf ? (sh[ACC_W-1] ? MIN_Q : MAX_Q) : sh[DW-1:0];
        wd   = {w[DW-1], w} - {ONE_Q[DW-1], ONE_Q};
        wad  = wd[DW] ? -wd : wd;
        rsh  = {rem_reg[DW-1:0], dvd_reg[DVD_W-1]};
        neg  = num[DW-1] ^ w[DW-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IDLE;
            ov_reg <= 1'b0;
        end else begin
            if (ov_reg && m_tready) ov_reg <= 1'b0;
            case (st_reg)
                S_IDLE: begin
                    if (!empty) begin
                        it_reg  <= head;
                        r_reg   <= '0;
                        k_reg   <= '0;
                        acc_reg <= '0;
                        sat_reg <= 1'b0;
                        div_reg <= 1'b0;
                        rv_reg  <= '0;
                        st_reg  <= (head.cmd == CMD_SET) ? S_FIN : S_RD;
                    end
                end
                S_RD: st_reg <= S_MUL;
                S_MUL: begin
                    if (it_reg.cmd == CMD_READ) begin
                        rv_reg <= rdata;
                        st_reg <= S_FIN;
                    end else begin
                        prod_reg <= rdata * vec;
                        st_reg   <= S_ACC;
                    end
                end
                S_ACC: begin
                    acc_reg <= acc_reg + ACC_W'(prod_reg);
                    k_reg   <= k_reg + 2'd1;
                    st_reg  <= (k_reg == 2'd3) ? S_ROW : S_RD;
                end
                S_ROW: begin
                    sum_reg[r_reg] <= rowv;
                    if (ovf && (r_reg != 2'd3 || pt)) sat_reg <= 1'b1;
                    acc_reg <= '0;
                    r_reg   <= r_reg + 2'd1;
                    st_reg  <= (r_reg == 2'd3) ? S_CHK : S_RD;
                end
                S_CHK: begin
                    ch_reg <= '0;
                    if (pt && (wad > $signed({17'd0, tol}))) begin
                        div_reg <= 1'b1;
                        st_reg  <= S_DSTART;
                    end else begin
                        st_reg  <= S_FIN;
                    end
                end
                S_DSTART: begin
                    if (w == '0) begin
                        sat_reg <= 1'b1;
                        sum_reg[ch_reg] <= num[DW-1] ? MIN_Q :
                                           ((num == '0) ? '0 : MAX_Q);
                        ch_reg <= ch_reg + 2'd1;
                        st_reg <= (ch_reg == 2'd2) ? S_FIN : S_DSTART;
                    end else begin
                        dvd_reg <= {(num[DW-1] ? DW'(-num) : DW'(num)),
                                    {FRAC_BITS{1'b0}}};
                        dvs_reg <= w[DW-1] ? DW'(-w) : DW'(w);
                        rem_reg <= '0;
                        quo_reg <= '0;
                        cnt_reg <= CNT_W'(DVD_W);
                        st_reg  <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (rsh >= {1'b0, dvs_reg}) begin
                        rem_reg <= rsh - {1'b0, dvs_reg};
                        quo_reg <= {quo_reg[DVD_W-2:0], 1'b1};
                    end else begin
                        rem_reg <= rsh;
                        quo_reg <= {quo_reg[DVD_W-2:0], 1'b0};
                    end
                    dvd_reg <= dvd_reg << 1;
                    cnt_reg <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1)) st_reg <= S_DEND;
                end
                S_DEND: begin
                    if (neg) begin
                        if (quo_reg > DVD_W'({1'b1, {(DW-1){1'b0}}})) begin
                            sum_reg[ch_reg] <= MIN_Q;
                            sat_reg <= 1'b1;
                        end else begin
                            sum_reg[ch_reg] <= -$signed(quo_reg[DW-1:0]);
                        end
                    end else begin
                        if (quo_reg > DVD_W'(MAX_Q)) begin
                            sum_reg[ch_reg] <= MAX_Q;
                            sat_reg <= 1'b1;
                        end else begin
                            sum_reg[ch_reg] <= quo_reg[DW-1:0];
                        end
                    end
                    ch_reg <= ch_reg + 2'd1;
                    st_reg <= (ch_reg == 2'd2) ? S_FIN : S_DSTART;
                end
                S_FIN: begin
                    if (!ov_reg || m_tready) begin
                        ov_reg <= 1'b1;
                        if (it_reg.cmd == CMD_POINT || it_reg.cmd == CMD_DIR) begin
                            od_reg <= {rv_reg, sum_reg[2], sum_reg[1], sum_reg[0]};
                        end else begin
                            od_reg <= {rv_reg, {(3*DW){1'b0}}};
                        end
                        ou_reg <= {sat_reg, div_reg};
                        st_reg <= S_IDLE;
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

endmodule

/* rtl/vertex_transform_perspective_divide_core.sv */
// ----------------------------------------------------------------------------
// vertex_transform_perspective_divide_core
// 4x4 Q16.16 point/direction transform with perspective divide.
// ----------------------------------------------------------------------------
// Direction: 16 terms through the single shared 32x32 multiplier, each in the read,
// multiply and accumulate states, plus rounding of each row. Set and read bypass it.
// Point: as direction, plus a bit-serial division of each coordinate when divided,
// or each is clamped by its sign when w is zero. One transaction in the engine at a time;
// queue holds two more. Output stalls hold the finished result in the engine.
// Reset (aresetn low, synchronous) restores the identity matrix and tolerance 1.
module vertex_transform_perspective_divide_core
    import vtpd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,  // entry_index, entry_value, in_x, in_y, in_z, pad
    input  logic [1:0]   s_tuser,  // command
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,  // out_x, out_y, out_z, read_value
    output logic [1:0]   m_tuser,  // divided, saturated
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    qslot_t      push;
    logic        full, empty, pop;
    item_t       head;
    logic [15:0] tol_reg;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_TOL) ? {16'd0, tol_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= 16'd1;
        end else if (psel && penable && pwrite && paddr == ADDR_TOL) begin
            tol_reg <= pwdata[15:0];
        end
    end

    vtpd_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .s_tuser(s_tuser),
        .push(push), .full(full)
    );

    vtpd_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push(push), .full(full), .empty(empty),
        .pop(pop), .head(head)
    );

    vtpd_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .empty(empty), .pop(pop), .head(head), .tol(tol_reg),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

endmodule

/* rtl/vtpd_checker.sv */
// ----------------------------------------------------------------------------
// vtpd_checker
// Port-level checks for the transform core.
// ----------------------------------------------------------------------------
module vtpd_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic [1:0]   m_tuser,
    input logic         pready
);

    a_rst_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_div_no_rv: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[127:96] == 32'd0)
        else $error("divided result carries read value");

    a_pready: assert property (@(posedge aclk) pready)
        else $error("pready low");

endmodule

bind vertex_transform_perspective_divide_core vtpd_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser), .pready(pready)
);

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex transform and perspective divide testbench
// Drives set, read, point and direction transactions over the input stream.
// The unity tolerance is changed over APB between phases, while the block is
// idle. Each transaction's expected result is computed when it is accepted
// and queued. Every result on the output stream is compared field by field
// with the oldest queued entry. Random idle cycles are inserted on both sides.
// ----------------------------------------------------------------------------
module testbench;
    import vtpd_pkg::*;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] rv;
        logic               div;
        logic               sat;
    } vertex_res_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [135:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    logic signed [31:0] mat_model [16];
    logic [15:0]        tol_model;
    vertex_res_t        pending_vertices [$];
    int                 errors = 0;
    bit                 quiet = 1'b0;
    int                 stall_cnt = 0;

    vertex_transform_perspective_divide_core dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint row_dot(int r, longint a, longint b, longint c, bit with_t,
                                       inout bit sat);
        logic signed [79:0] s;
        longint p0, p1, p2, p3;
        p0 = longint'(mat_model[r]) * a;
        p1 = longint'(mat_model[r+4]) * b;
        p2 = longint'(mat_model[r+8]) * c;
        p3 = with_t ? longint'(mat_model[r+12]) * 65536 : 0;
        s = 80'(p0) + 80'(p1) + 80'(p2) + 80'(p3);
        s = (s + 80'sd32768) >>> FRAC_BITS;
        if (s > 80'sd2147483647) begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (s < -80'sd2147483648) begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return longint'(s);
    endfunction

    function automatic longint div_by_w(longint num, longint w, inout bit sat);
        longint q;
        if (w == 0) begin
            sat = 1'b1;
            return num > 0 ? 64'sd2147483647 : (num < 0 ? -64'sd2147483648 : 0);
        end
        q = (num * 65536) / w;
        if (q > 64'sd2147483647) begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (q < -64'sd2147483648) begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return q;
    endfunction

    function automatic vertex_res_t project_vertex(cmd_t cmd, logic [3:0] idx,
            logic signed [31:0] val, logic signed [31:0] ix, logic signed [31:0] iy,
            logic signed [31:0] iz);
        vertex_res_t r;
        bit sat, pt;
        longint x, y, z, w, d;
        r = '0;
        sat = 1'b0;
        if (cmd == CMD_SET) begin
            mat_model[idx] = val;
        end else if (cmd == CMD_READ) begin
            r.rv = mat_model[idx];
        end else begin
            pt = (cmd == CMD_POINT);
            x = row_dot(0, ix, iy, iz, pt, sat);
            y = row_dot(1, ix, iy, iz, pt, sat);
            z = row_dot(2, ix, iy, iz, pt, sat);
            if (pt) begin
                w = row_dot(3, ix, iy, iz, 1'b1, sat);
                d = w - 65536;
                if (d < 0) d = -d;
                if (d > longint'(tol_model)) begin
                    r.div = 1'b1;
                    x = div_by_w(x, w, sat);
                    y = div_by_w(y, w, sat);
                    z = div_by_w(z, w, sat);
                end
            end
            r.x = x[31:0];
            r.y = y[31:0];
            r.z = z[31:0];
        end
        r.sat = sat;
        return r;
    endfunction

    task automatic send_item(cmd_t cmd, logic [3:0] idx, logic signed [31:0] val,
                             logic signed [31:0] ix, logic signed [31:0] iy,
                             logic signed [31:0] iz);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0, iz, iy, ix, val, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_vertices.push_back(project_vertex(cmd, idx, val, ix, iy, iz));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_vertices.size() != 0) @(posedge aclk);
    endtask

    task automatic write_tolerance(logic [15:0] tol);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_TOL;
        pwdata  <= {16'b0, tol};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tol_model = tol;
    endtask

    function automatic logic signed [31:0] rnd_q();
        case ($urandom_range(0, 4))
            0:       return $urandom;
            1:       return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
            2:       return $signed($urandom_range(0, 1 << 25)) - (1 << 24);
            default: return $signed($urandom_range(0, 1 << 17)) - (1 << 16);
        endcase
    endfunction

    always @(posedge aclk) begin
        if (stall_cnt > 0) begin
            stall_cnt <= stall_cnt - 1;
            m_tready  <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_cnt <= $urandom_range(0, 8);
            m_tready  <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        vertex_res_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_vertices.size() == 0) begin
                $error("unexpected result transaction");
                errors++;
            end else begin
                e = pending_vertices.pop_front();
                if (m_tdata[31:0] !== e.x) begin
                    $error("out_x expected %h actual %h", e.x, m_tdata[31:0]);
                    errors++;
                end
                if (m_tdata[63:32] !== e.y) begin
                    $error("out_y expected %h actual %h", e.y, m_tdata[63:32]);
                    errors++;
                end
                if (m_tdata[95:64] !== e.z) begin
                    $error("out_z expected %h actual %h", e.z, m_tdata[95:64]);
                    errors++;
                end
                if (m_tdata[127:96] !== e.rv) begin
                    $error("read_value expected %h actual %h", e.rv, m_tdata[127:96]);
                    errors++;
                end
                if (m_tuser[0] !== e.div) begin
                    $error("divided expected %b actual %b", e.div, m_tuser[0]);
                    errors++;
                end
                if (m_tuser[1] !== e.sat) begin
                    $error("saturated expected %b actual %b", e.sat, m_tuser[1]);
                    errors++;
                end
            end
        end
    end

    task automatic test_reset_matrix();
        for (int i = 0; i < 16; i++) send_item(CMD_READ, 4'(i), '0, '0, '0, '0);
    endtask

    task automatic test_directed();
        send_item(CMD_POINT, 4'd0, '0, 32'sh0001_8000, -32'sh0002_0000, '0);
        send_item(CMD_DIR, 4'd0, '1, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh0000_0001);
        send_item(CMD_SET, 4'd15, '0, '0, '0, '0);
        send_item(CMD_POINT, 4'd0, '0, 32'sh0003_0000, -32'sh0001_0000, '0);
        send_item(CMD_SET, 4'd15, 32'sh0000_0001, '0, '0, '0);
        send_item(CMD_POINT, 4'd0, '0, 32'sh0100_0000, 32'sh0000_0001, -32'sh0000_0004);
        send_item(CMD_SET, 4'd15, 32'sh0002_0000, '0, '0, '0);
        send_item(CMD_POINT, 4'd0, '0, 32'sh0005_0000, -32'sh0003_0001, 32'sh0000_0007);
        send_item(CMD_SET, 4'd15, 32'sh0001_0001, '0, '0, '0);
        send_item(CMD_POINT, 4'd0, '0, 32'sh0005_0000, 32'sh0001_0000, 32'sh0002_0000);
        send_item(CMD_SET, 4'd0, 32'sh7fff_ffff, '0, '0, '0);
        send_item(CMD_SET, 4'd12, 32'sh8000_0000, '0, '0, '0);
        send_item(CMD_DIR, 4'd0, '0, 32'sh7fff_ffff, '0, '0);
        send_item(CMD_POINT, 4'd0, '0, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000);
        send_item(CMD_READ, 4'd0, '0, '0, '0, '0);
        send_item(CMD_READ, 4'd12, '0, '0, '0, '0);
        send_item(CMD_SET, 4'd3, 32'sh0000_8000, '0, '0, '0);
        send_item(CMD_POINT, 4'd0, '0, 32'sh0000_0001, 32'sh0001_0000, 32'sh0001_0000);
        send_item(CMD_READ, 4'd15, '0, '0, '0, '0);
    endtask

    task automatic test_random_phase(logic [15:0] tol, int count, bit last);
        cmd_t cmd;
        write_tolerance(tol);
        for (int n = 0; n < 16; n++)
            send_item(CMD_SET, 4'(n), (n % 5 == 0) ? rnd_q() | 32'sh0000_8000 : rnd_q(),
                      '0, '0, '0);
        for (int n = 0; n < count; n++) begin
            if (last && n > count - 120) quiet = 1'b1;
            case ($urandom_range(0, 19))
                0, 1, 2, 3: send_item(CMD_SET, 4'($urandom), rnd_q(), $urandom, $urandom,
                                      $urandom);
                4:          send_item(CMD_READ, 4'($urandom), $urandom, $urandom, $urandom,
                                      $urandom);
                5: begin
                    send_item(CMD_SET, 4'd3, '0, '0, '0, '0);
                    send_item(CMD_SET, 4'd7, '0, '0, '0, '0);
                    send_item(CMD_SET, 4'd11, '0, '0, '0, '0);
                    send_item(CMD_SET, 4'd15, 32'sh0001_0000 + $signed($urandom_range(0, 64))
                              - 32, '0, '0, '0);
                end
                6, 7, 8, 9, 10, 11, 12:
                    send_item(CMD_POINT, 4'($urandom), $urandom, rnd_q(), rnd_q(), rnd_q());
                default:
                    send_item(CMD_DIR, 4'($urandom), $urandom, rnd_q(), rnd_q(), rnd_q());
            endcase
        end
        drain();
    endtask

    initial begin
        #50_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        for (int i = 0; i < 16; i++) mat_model[i] = (i % 5 == 0) ? 32'sh0001_0000 : '0;
        tol_model = 16'd1;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_matrix();
        test_directed();
        write_tolerance(16'd0);
        test_directed();
        test_random_phase(16'hffff, 350, 1'b0);
        test_random_phase(16'd0, 350, 1'b0);
        test_random_phase(16'($urandom_range(0, 65535)), 350, 1'b0);
        test_random_phase(16'd32, 400, 1'b1);
        repeat (300) @(posedge aclk);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/vtpd_pkg.sv
rtl/vtpd_front.sv
rtl/vtpd_queue.sv
rtl/vtpd_back.sv
rtl/vertex_transform_perspective_divide_core.sv
rtl/vtpd_checker.sv
tb/testbench.sv
